@@ design/obb_overlap_contact_tracker_defines.svh @@
// assertion macros for the oriented rectangle overlap contact tracker
`ifndef OBB_OVERLAP_CONTACT_TRACKER_DEFINES_SVH
`define OBB_OVERLAP_CONTACT_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OBBCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OBBCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/obbct_pkg.sv @@
// shared types and constants for the oriented rectangle overlap contact tracker
package obbct_pkg;

    localparam int SLOT_W   = 10;
    localparam int FLAG_W   = 2;
    localparam int EVENT_W  = 2;
    localparam int EDGES    = 4;
    localparam int DOTS     = EDGES + 1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic valid;
        logic half;
        logic center;
        logic first;
    } t_tag;

endpackage

@@ design/obbct_ram.sv @@
// generic single write port ram with registered read
module obbct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/obb_overlap_contact_tracker.sv @@
// separating axis overlap test of two oriented rectangles with per-pair contact tracking
// the forty products go one per cycle through the single shared multiplier
// one item at a time: the next item is taken only after the result register is loaded
// reset: synchronous, then a clearing pass over the touching table with input stall held high
module obb_overlap_contact_tracker #(
    parameter int PAIR_SLOTS  = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [obbct_pkg::SLOT_W-1:0]      i_pair_slot,
    input  logic signed [COORD_WIDTH-1:0]     i_left_edge_a_x,
    input  logic signed [COORD_WIDTH-1:0]     i_left_edge_a_y,
    input  logic signed [COORD_WIDTH-1:0]     i_left_edge_b_x,
    input  logic signed [COORD_WIDTH-1:0]     i_left_edge_b_y,
    input  logic signed [COORD_WIDTH-1:0]     i_right_edge_a_x,
    input  logic signed [COORD_WIDTH-1:0]     i_right_edge_a_y,
    input  logic signed [COORD_WIDTH-1:0]     i_right_edge_b_x,
    input  logic signed [COORD_WIDTH-1:0]     i_right_edge_b_y,
    input  logic signed [COORD_WIDTH-1:0]     i_center_dx,
    input  logic signed [COORD_WIDTH-1:0]     i_center_dy,
    input  logic [obbct_pkg::FLAG_W-1:0]      i_trigger_flags,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [obbct_pkg::SLOT_W-1:0]      o_out_slot,
    output logic                              o_overlapping,
    output logic [obbct_pkg::EVENT_W-1:0]     o_contact_event,
    output logic                              o_left_trigger_kind,
    output logic                              o_right_trigger_kind
);

    import obbct_pkg::*;
    `include "obb_overlap_contact_tracker_defines.svh"

    localparam int AW   = $clog2(PAIR_SLOTS);
    localparam int W    = COORD_WIDTH;
    localparam int PW   = 2 * W;
    localparam int DW   = 2 * W + 1;
    localparam int MW   = 2 * W;
    localparam int SW   = 2 * W + 2;
    localparam int EW   = $clog2(DOTS);
    localparam int KW   = $clog2(EDGES);
    localparam int RS   = SLOT_W + 17;
    localparam int QW   = SLOT_W + RS;
    localparam int RMW  = SLOT_W + 17;
    localparam logic [RS-1:0] RECIP =
        RS'(((64'd1 << RS) + 64'(PAIR_SLOTS) - 64'd1) / 64'(PAIR_SLOTS));

    t_state r_state;
    t_state n_state;

    // operand rings
    logic signed [W-1:0] r_rx [DOTS];
    logic signed [W-1:0] r_ry [DOTS];
    logic signed [W-1:0] r_ax [EDGES];
    logic signed [W-1:0] r_ay [EDGES];

    logic          r_h;
    logic [EW-1:0] r_e;
    logic [KW-1:0] r_k;

    t_tag r_t1, r_t2, r_t3, r_t4;
    t_tag issue_tag;

    logic signed [PW-1:0] mul_a_ext;
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_part;
    logic signed [DW-1:0] r_dot;
    logic [MW-1:0]        r_mag;
    logic [MW-1:0]        r_cmag;
    logic [SW-1:0]        r_sum;
    logic                 r_sep;
    logic signed [DW-1:0] dot_neg;

    logic [SLOT_W-1:0]     r_slot;
    logic [FLAG_W-1:0]     r_flags;
    logic [QW-1:0]         quot_prod;
    logic [SLOT_W-1:0]     r_quot;
    logic [RMW-1:0]        rem_full;
    logic [AW-1:0]         r_idx;

    logic [AW-1:0] r_clr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_rdata;

    logic   in_accept;
    logic   issue_last;
    logic   pipe_busy;
    logic   out_load;
    logic   overlap;
    t_event event_code;

    logic                r_o_valid;
    logic [SLOT_W-1:0]   r_o_slot;
    logic                r_o_overlap;
    t_event              r_o_event;
    logic                r_o_left;
    logic                r_o_right;

    assign in_accept  = i_valid && !o_stall;
    assign issue_last = (r_k == KW'(EDGES - 1)) && (r_e == EW'(DOTS - 1)) && r_h;
    assign pipe_busy  = r_t1.valid || r_t2.valid || r_t3.valid || r_t4.valid;

    assign issue_tag.valid  = (r_state == ST_ISSUE);
    assign issue_tag.half   = r_h;
    assign issue_tag.center = (r_e == EW'(DOTS - 1));
    assign issue_tag.first  = (r_e == '0);

    assign mul_a     = r_h ? r_ry[0] : r_rx[0];
    assign mul_b     = r_h ? r_ay[0] : r_ax[0];
    assign mul_a_ext = PW'(mul_a);
    assign dot_neg   = -r_dot;

    // slot reduction by reciprocal multiply
    assign quot_prod = QW'(r_slot) * QW'(RECIP);
    assign rem_full  = RMW'(r_slot) - RMW'(r_quot) * RMW'(PAIR_SLOTS);

    assign overlap = !r_sep;

    obbct_ram #(
        .WIDTH (1),
        .DEPTH (PAIR_SLOTS)
    ) u_touch_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = overlap;
        out_load   = 1'b0;
        o_stall    = 1'b1;
        event_code = EV_NONE;
        if (overlap) begin
            event_code = ram_rdata ? EV_STAY : EV_ENTER;
        end else if (ram_rdata) begin
            event_code = EV_EXIT;
        end
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 1'b0;
                if (r_clr == AW'(PAIR_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_o_valid || !i_stall) begin
                    out_load = 1'b1;
                    ram_we   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_t1      <= '0;
            r_t2      <= '0;
            r_t3      <= '0;
            r_t4      <= '0;
            r_o_valid <= 1'b0;
            r_h       <= 1'b0;
            r_e       <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_t1 <= issue_tag;
            r_t2 <= '{valid: r_t1.valid && r_t1.half, half: r_t1.half,
                      center: r_t1.center, first: r_t1.first};
            r_t3 <= r_t2;
            r_t4 <= '{valid: r_t3.valid && r_t3.center, half: r_t3.half,
                      center: r_t3.center, first: r_t3.first};
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (in_accept) begin
                r_h   <= 1'b0;
                r_e   <= '0;
                r_k   <= '0;
            end else if (r_state == ST_ISSUE) begin
                r_h <= !r_h;
                if (r_h) begin
                    if (r_e == EW'(DOTS - 1)) begin
                        r_e <= '0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rx[0] <= i_left_edge_a_x;
            r_ry[0] <= i_left_edge_a_y;
            r_rx[1] <= i_left_edge_b_x;
            r_ry[1] <= i_left_edge_b_y;
            r_rx[2] <= i_right_edge_a_x;
            r_ry[2] <= i_right_edge_a_y;
            r_rx[3] <= i_right_edge_b_x;
            r_ry[3] <= i_right_edge_b_y;
            r_rx[4] <= i_center_dx;
            r_ry[4] <= i_center_dy;
            r_ax[0] <= i_left_edge_a_x;
            r_ay[0] <= i_left_edge_a_y;
            r_ax[1] <= i_left_edge_b_x;
            r_ay[1] <= i_left_edge_b_y;
            r_ax[2] <= i_right_edge_a_x;
            r_ay[2] <= i_right_edge_a_y;
            r_ax[3] <= i_right_edge_b_x;
            r_ay[3] <= i_right_edge_b_y;
            r_slot  <= i_pair_slot;
            r_flags <= i_trigger_flags;
            r_sep   <= 1'b0;
        end else if (r_state == ST_ISSUE) begin
            if (r_h) begin
                for (int i = 0; i < DOTS - 1; i++) begin
                    r_rx[i] <= r_rx[i+1];
                    r_ry[i] <= r_ry[i+1];
                end
                r_rx[DOTS-1] <= r_rx[0];
                r_ry[DOTS-1] <= r_ry[0];
                if (r_e == EW'(DOTS - 1)) begin
                    for (int i = 0; i < EDGES - 1; i++) begin
                        r_ax[i] <= r_ax[i+1];
                        r_ay[i] <= r_ay[i+1];
                    end
                    r_ax[EDGES-1] <= r_ax[0];
                    r_ay[EDGES-1] <= r_ay[0];
                end
            end
        end

        r_quot <= quot_prod[QW-1:RS];
        r_idx  <= rem_full[AW-1:0];

        r_prod <= mul_a_ext * PW'(mul_b);

        if (r_t1.valid) begin
            if (!r_t1.half) begin
                r_part <= r_prod;
            end else begin
                r_dot <= {r_part[PW-1], r_part} + {r_prod[PW-1], r_prod};
            end
        end

        r_mag <= r_dot[DW-1] ? dot_neg[MW-1:0] : r_dot[MW-1:0];

        if (r_t3.valid) begin
            if (r_t3.center) begin
                r_cmag <= r_mag;
            end else if (r_t3.first) begin
                r_sum <= SW'(r_mag);
            end else begin
                r_sum <= r_sum + SW'(r_mag);
            end
        end

        // axis separates when the edge spread falls short of twice the center projection
        if (r_t4.valid && (r_sum < {1'b0, r_cmag, 1'b0})) begin
            r_sep <= 1'b1;
        end

        if (out_load) begin
            r_o_slot    <= r_slot;
            r_o_overlap <= overlap;
            r_o_event   <= event_code;
            r_o_left    <= (event_code != EV_NONE) && r_flags[0];
            r_o_right   <= (event_code != EV_NONE) && r_flags[1];
        end
    end

    assign o_valid              = r_o_valid;
    assign o_out_slot           = r_o_slot;
    assign o_overlapping        = r_o_overlap;
    assign o_contact_event      = r_o_event;
    assign o_left_trigger_kind  = r_o_left;
    assign o_right_trigger_kind = r_o_right;

    `OBBCT_ASSERT_NOW(a_event_matches_overlap, i_clk, i_rst_n, r_o_valid, ((r_o_event == EV_ENTER) || (r_o_event == EV_STAY)) == r_o_overlap, "contact event disagrees with overlap")
    `OBBCT_ASSERT_NOW(a_no_event_no_trigger, i_clk, i_rst_n, r_o_valid && (r_o_event == EV_NONE), !r_o_left && !r_o_right, "trigger kind set without an event")
    `OBBCT_ASSERT_NOW(a_table_write_window, i_clk, i_rst_n, ram_we, (r_state == ST_CLEAR) || (r_state == ST_RESULT), "touching table written outside clear or result")
    `OBBCT_ASSERT_NEXT(a_accept_starts_issue, i_clk, i_rst_n, in_accept, (r_state == ST_ISSUE) && !r_t1.valid, "accepted request did not start the multiply sequence")
    `OBBCT_ASSERT_NOW(a_stall_outside_idle, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "request taken outside idle")

endmodule
